@@ src/pbc_pkg.sv @@
// Package for the pixel blend compositor: types, fixed-point constants and lookup tables.
`timescale 1ns / 1ps

package pbc_pkg;

	// Pipeline register stages between the input and the output register.
	localparam int NUM_STG = 15;

	localparam logic [16:0] Q_ONE     = 17'd65536;
	localparam logic [16:0] Q_HALF    = 17'd32768;
	localparam logic [16:0] Q_QUARTER = 17'd16384;

	typedef enum logic [1:0] {
		MODE_OVER     = 2'd0,
		MODE_MULTIPLY = 2'd1,
		MODE_SCREEN   = 2'd2,
		MODE_SOFT     = 2'd3
	} blend_mode_t;

	typedef logic [16:0] q16_t;
	typedef q16_t q16_tab_t [256];

	// Byte to Q16: floor((c*65536 + 127) / 255).
	function automatic q16_tab_t build_q16_tab();
		q16_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 17'(((i * 65536) + 127) / 255);
		end
		return t;
	endfunction

	// floor(sqrt(q16(c) * 65536)) for each destination byte.
	function automatic q16_tab_t build_sqrt_tab();
		q16_tab_t t;
		longint   v;
		longint   r;
		longint   trial;
		for (int i = 0; i < 256; i++) begin
			v = longint'(((i * 65536) + 127) / 255) * 65536;
			r = 0;
			for (int b = 16; b >= 0; b--) begin
				trial = r + (longint'(1) << b);
				if (trial * trial <= v) begin
					r = trial;
				end
			end
			t[i] = 17'(r);
		end
		return t;
	endfunction

	localparam q16_tab_t Q16_TAB  = build_q16_tab();
	localparam q16_tab_t SQRT_TAB = build_sqrt_tab();

endpackage

@@ src/pixel_blend_compositor_top.sv @@
// Top level of the pixel blend compositor: a fully pipelined RGBA8 blend and composite datapath.
`timescale 1ns / 1ps

// Pixel blend compositor.
// Input channel (s_*): one item per source color and destination pixel.
//   s_tdata: src_red 7:0, src_green 15:8, src_blue 23:16, src_alpha 31:24,
//   dst_pixel 63:32.
// Output channel (m_*): m_tdata carries result_pixel, m_tuser write_enable.
// Config: cfg_we writes cfg_wdata into the blend mode register (0 source-over,
//   1 multiply, 2 screen, 3 soft-light); write only while the pipe is empty.
// Throughput: one item per clock while m_tready stays high. Every pipeline stage advances on its own
//   when its successor moves or is empty, so bubbles are squeezed out.
// Depth: 15 datapath stages plus the output register between acceptance and
//   m_tvalid. The depth is set by the soft-light chain (three chained
//   multiplies), the mix and the composite multiply, and the 8-bit quotient
//   by output alpha, taken two bits per stage over four stages.
// Stall: when m_tready is low, the held result stays put, earlier stages keep
//   filling until every stage holds an item, then s_tready drops.
// Reset: all valid bits clear, blend mode returns to source-over.
// Zero source alpha: the destination passes through with write_enable low.
module pixel_blend_compositor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // src_red, src_green, src_blue, src_alpha, dst_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // result_pixel
	output logic        m_tuser     // write_enable
);

	localparam int NS = pbc_pkg::NUM_STG;

	pbc_pkg::blend_mode_t blend_mode_q;

	logic [NS:1]   vld_q;
	logic [NS+1:1] adv;
	logic          out_vld_q;
	logic [31:0]   out_pix_q;
	logic          out_we_q;

	// ---------------- handshake ----------------
	// A stage loads when it is empty or its successor loads.
	always_comb begin
		adv[NS+1] = !out_vld_q || m_tready;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign s_tready = adv[1];
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_pix_q;
	assign m_tuser  = out_we_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			out_vld_q    <= 1'b0;
			blend_mode_q <= pbc_pkg::MODE_OVER;
		end else begin
			if (cfg_we) begin
				blend_mode_q <= pbc_pkg::blend_mode_t'(cfg_wdata);
			end
			if (adv[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (adv[NS+1]) begin
				out_vld_q <= vld_q[NS];
			end
		end
	end

	// ---------------- datapath registers ----------------
	// stage 1: table lookups
	logic [16:0] cb_s1 [3], cs_s1 [3], sqr_s1 [3];
	logic [16:0] as_s1, ab_s1;
	logic        we_s1;
	logic [31:0] dst_s1;
	// stage 2: first products
	logic [16:0] cb_s2 [3], cs_s2 [3], sqr_s2 [3];
	logic [33:0] mmul_s2 [3], mscr_s2 [3], mcc_s2 [3], msq_s2 [3], mcbab_s2 [3], mcs1_s2 [3];
	logic [33:0] prod_ao_s2;
	logic [16:0] as_s2, ab_s2;
	logic        we_s2;
	logic [31:0] dst_s2;
	// stage 3
	logic [16:0] cb_s3 [3], cs_s3 [3], sqr_s3 [3], bmul_s3 [3], bscr_s3 [3];
	logic [50:0] tprod_s3 [3], cbab1_s3 [3];
	logic [19:0] p_s3 [3];
	logic [33:0] mcs1_s3 [3];
	logic [16:0] as_s3, ab_s3, ao_s3;
	logic        we_s3;
	logic [31:0] dst_s3;
	// stage 4
	logic [16:0] cb_s4 [3], cs_s4 [3], sqr_s4 [3], bmul_s4 [3], bscr_s4 [3], sllo_s4 [3];
	logic [36:0] dprod_s4 [3];
	logic [33:0] mcs1_s4 [3];
	logic [50:0] cbab1_s4 [3];
	logic [16:0] as_s4, ab_s4, ao_s4;
	logic [7:0]  alpha_s4;
	logic        we_s4;
	logic [31:0] dst_s4;
	// stage 5
	logic [16:0] cb_s5 [3], cs_s5 [3], bmul_s5 [3], bscr_s5 [3], sllo_s5 [3];
	logic [19:0] diff_s5 [3];
	logic [33:0] mcs1_s5 [3];
	logic [50:0] cbab1_s5 [3];
	logic [16:0] as_s5, ab_s5, ao_s5;
	logic [7:0]  alpha_s5;
	logic        we_s5;
	logic [31:0] dst_s5;
	// stage 6
	logic [16:0] cb_s6 [3], cs_s6 [3], bmul_s6 [3], bscr_s6 [3], sllo_s6 [3];
	logic [36:0] hprod_s6 [3];
	logic [33:0] mcs1_s6 [3];
	logic [50:0] cbab1_s6 [3];
	logic [16:0] as_s6, ab_s6, ao_s6;
	logic [7:0]  alpha_s6;
	logic        we_s6;
	logic [31:0] dst_s6;
	// stage 7: blend result
	logic [16:0] b_s7 [3];
	logic [33:0] mcs1_s7 [3];
	logic [50:0] cbab1_s7 [3];
	logic [16:0] as_s7, ab_s7, ao_s7;
	logic [7:0]  alpha_s7;
	logic        we_s7;
	logic [31:0] dst_s7;
	// stage 8: mix sum
	logic [34:0] mixsum_s8 [3];
	logic [50:0] cbab1_s8 [3];
	logic [16:0] as_s8, ao_s8;
	logic [7:0]  alpha_s8;
	logic        we_s8;
	logic [31:0] dst_s8;
	// stage 9: mixed * as
	logic [35:0] mas_s9 [3];
	logic [50:0] cbab1_s9 [3];
	logic [16:0] ao_s9;
	logic [7:0]  alpha_s9;
	logic        we_s9;
	logic [31:0] dst_s9;
	// stage 10: numerator
	logic [51:0] num_s10 [3];
	logic [16:0] ao_s10;
	logic [7:0]  alpha_s10;
	logic        we_s10;
	logic [31:0] dst_s10;
	// stage 11: scaled dividend
	logic [27:0] nh_s11 [3];
	logic [16:0] ao_s11;
	logic [7:0]  alpha_s11;
	logic        we_s11;
	logic [31:0] dst_s11;
	// stages 12..15: restoring division, two quotient bits per stage
	logic [27:0] rem_s12 [3], rem_s13 [3], rem_s14 [3];
	logic [7:0]  q_s12 [3], q_s13 [3], q_s14 [3], q_s15 [3];
	logic        sat_s12 [3], sat_s13 [3], sat_s14 [3], sat_s15 [3];
	logic [16:0] ao_s12, ao_s13, ao_s14;
	logic [7:0]  alpha_s12, alpha_s13, alpha_s14, alpha_s15;
	logic        we_s12, we_s13, we_s14, we_s15;
	logic [31:0] dst_s12, dst_s13, dst_s14, dst_s15;

	function automatic logic [28:0] div_step(input logic [27:0] rem, input logic [27:0] dv);
		div_step = (rem >= dv) ? {1'b1, rem - dv} : {1'b0, rem};
	endfunction

	// ---------------- combinational stage logic ----------------
	logic [16:0] b_nx [3];
	logic [28:0] d12a [3], d12b [3], d13a [3], d13b [3];
	logic [28:0] d14a [3], d14b [3], d15a [3], d15b [3];
	logic [7:0]  byte_nx [3];

	always_comb begin
		logic [51:0] tr;
		logic [21:0] slhi;
		logic [16:0] sllo;
		for (int c = 0; c < 3; c++) begin
			tr   = 52'(hprod_s6[c]) + 52'(pbc_pkg::Q_HALF);
			slhi = 22'(cb_s6[c]) + 22'(tr >> 16);
			sllo = (slhi > 22'(pbc_pkg::Q_ONE)) ? pbc_pkg::Q_ONE : slhi[16:0];
			case (blend_mode_q)
				pbc_pkg::MODE_OVER:     b_nx[c] = cs_s6[c];
				pbc_pkg::MODE_MULTIPLY: b_nx[c] = bmul_s6[c];
				pbc_pkg::MODE_SCREEN:   b_nx[c] = bscr_s6[c];
				pbc_pkg::MODE_SOFT:
					b_nx[c] = (cs_s6[c] <= pbc_pkg::Q_HALF) ? sllo_s6[c] : sllo;
				default:                b_nx[c] = cs_s6[c];
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d12a[c] = div_step(nh_s11[c], 28'(ao_s11) << 7);
			d12b[c] = div_step(d12a[c][27:0], 28'(ao_s11) << 6);
			d13a[c] = div_step(rem_s12[c], 28'(ao_s12) << 5);
			d13b[c] = div_step(d13a[c][27:0], 28'(ao_s12) << 4);
			d14a[c] = div_step(rem_s13[c], 28'(ao_s13) << 3);
			d14b[c] = div_step(d14a[c][27:0], 28'(ao_s13) << 2);
			d15a[c] = div_step(rem_s14[c], 28'(ao_s14) << 1);
			d15b[c] = div_step(d15a[c][27:0], 28'(ao_s14));
			byte_nx[c] = sat_s15[c] ? 8'hFF : q_s15[c];
		end
	end

	// ---------------- payload pipeline ----------------
	always_ff @(posedge clk) begin
		logic [39:0] pw;
		logic [37:0] dr;
		logic [19:0] dsel;
		logic [51:0] tw;
		logic [35:0] mr;
		logic [59:0] nw;
		logic [24:0] aw;
		logic [17:0] kk;
		logic [17:0] hh;

		// stage 1
		if (adv[1]) begin
			for (int c = 0; c < 3; c++) begin
				cb_s1[c]  <= pbc_pkg::Q16_TAB[s_tdata[32 + 8*c +: 8]];
				sqr_s1[c] <= pbc_pkg::SQRT_TAB[s_tdata[32 + 8*c +: 8]];
				cs_s1[c]  <= pbc_pkg::Q16_TAB[s_tdata[8*c +: 8]];
			end
			as_s1  <= pbc_pkg::Q16_TAB[s_tdata[31:24]];
			ab_s1  <= pbc_pkg::Q16_TAB[s_tdata[63:56]];
			we_s1  <= (s_tdata[31:24] != 8'd0);
			dst_s1 <= s_tdata[63:32];
		end

		// stage 2
		if (adv[2]) begin
			for (int c = 0; c < 3; c++) begin
				cb_s2[c]    <= cb_s1[c];
				cs_s2[c]    <= cs_s1[c];
				sqr_s2[c]   <= sqr_s1[c];
				mmul_s2[c]  <= 34'(cb_s1[c]) * 34'(cs_s1[c]);
				mscr_s2[c]  <= 34'(pbc_pkg::Q_ONE - cb_s1[c]) * 34'(pbc_pkg::Q_ONE - cs_s1[c]);
				mcc_s2[c]   <= 34'(cb_s1[c]) * 34'(pbc_pkg::Q_ONE - cb_s1[c]);
				msq_s2[c]   <= 34'(cb_s1[c]) * 34'(cb_s1[c]);
				mcbab_s2[c] <= 34'(cb_s1[c]) * 34'(ab_s1);
				mcs1_s2[c]  <= 34'(pbc_pkg::Q_ONE - ab_s1) * 34'(cs_s1[c]);
			end
			prod_ao_s2 <= 34'(ab_s1) * 34'(pbc_pkg::Q_ONE - as_s1);
			as_s2      <= as_s1;
			ab_s2      <= ab_s1;
			we_s2      <= we_s1;
			dst_s2     <= dst_s1;
		end

		// stage 3
		if (adv[3]) begin
			for (int c = 0; c < 3; c++) begin
				cb_s3[c]   <= cb_s2[c];
				cs_s3[c]   <= cs_s2[c];
				sqr_s3[c]  <= sqr_s2[c];
				mcs1_s3[c] <= mcs1_s2[c];
				bmul_s3[c] <= 17'((35'(mmul_s2[c]) + 35'(pbc_pkg::Q_HALF)) >> 16);
				bscr_s3[c] <= pbc_pkg::Q_ONE
					- 17'((35'(mscr_s2[c]) + 35'(pbc_pkg::Q_HALF)) >> 16);
				// k = 1 - 2cs, only meaningful for cs <= 0.5
				kk = 18'(pbc_pkg::Q_ONE) - {cs_s2[c], 1'b0};
				tprod_s3[c] <= 51'(kk[16:0]) * 51'(mcc_s2[c]);
				// p = 4 + 16cb^2 - 12cb, only meaningful for cb <= 0.25
				pw = 40'(4 * 65536) + ((({6'b0, msq_s2[c]} << 4) + 40'(pbc_pkg::Q_HALF)) >> 16)
					- 40'(cb_s2[c]) * 40'd12;
				p_s3[c]     <= pw[19:0];
				cbab1_s3[c] <= 51'(mcbab_s2[c]) * 51'(pbc_pkg::Q_ONE - as_s2);
			end
			ao_s3  <= as_s2 + 17'((35'(prod_ao_s2) + 35'(pbc_pkg::Q_HALF)) >> 16);
			as_s3  <= as_s2;
			ab_s3  <= ab_s2;
			we_s3  <= we_s2;
			dst_s3 <= dst_s2;
		end

		// stage 4
		if (adv[4]) begin
			for (int c = 0; c < 3; c++) begin
				cb_s4[c]    <= cb_s3[c];
				cs_s4[c]    <= cs_s3[c];
				sqr_s4[c]   <= sqr_s3[c];
				bmul_s4[c]  <= bmul_s3[c];
				bscr_s4[c]  <= bscr_s3[c];
				mcs1_s4[c]  <= mcs1_s3[c];
				cbab1_s4[c] <= cbab1_s3[c];
				tw = 52'(tprod_s3[c]) + (52'(1) << 31);
				sllo_s4[c]  <= (tw[51:32] > 20'(cb_s3[c])) ? 17'd0 : cb_s3[c] - tw[48:32];
				dprod_s4[c] <= 37'(p_s3[c]) * 37'(cb_s3[c]);
			end
			aw = (25'(ao_s3) << 8) - 25'(ao_s3) + 25'(pbc_pkg::Q_HALF);
			alpha_s4 <= (aw[24:16] > 9'd255) ? 8'hFF : aw[23:16];
			as_s4    <= as_s3;
			ab_s4    <= ab_s3;
			ao_s4    <= ao_s3;
			we_s4    <= we_s3;
			dst_s4   <= dst_s3;
		end

		// stage 5: soft-light d and d - cb
		if (adv[5]) begin
			for (int c = 0; c < 3; c++) begin
				cb_s5[c]    <= cb_s4[c];
				cs_s5[c]    <= cs_s4[c];
				bmul_s5[c]  <= bmul_s4[c];
				bscr_s5[c]  <= bscr_s4[c];
				sllo_s5[c]  <= sllo_s4[c];
				mcs1_s5[c]  <= mcs1_s4[c];
				cbab1_s5[c] <= cbab1_s4[c];
				dr   = 38'(dprod_s4[c]) + 38'(pbc_pkg::Q_HALF);
				dsel = (cb_s4[c] <= pbc_pkg::Q_QUARTER) ? dr[35:16] : 20'(sqr_s4[c]);
				diff_s5[c] <= (dsel > 20'(cb_s4[c])) ? dsel - 20'(cb_s4[c]) : 20'd0;
			end
			as_s5    <= as_s4;
			ab_s5    <= ab_s4;
			ao_s5    <= ao_s4;
			alpha_s5 <= alpha_s4;
			we_s5    <= we_s4;
			dst_s5   <= dst_s4;
		end

		// stage 6: (2cs - 1) * diff
		if (adv[6]) begin
			for (int c = 0; c < 3; c++) begin
				cb_s6[c]    <= cb_s5[c];
				cs_s6[c]    <= cs_s5[c];
				bmul_s6[c]  <= bmul_s5[c];
				bscr_s6[c]  <= bscr_s5[c];
				sllo_s6[c]  <= sllo_s5[c];
				mcs1_s6[c]  <= mcs1_s5[c];
				cbab1_s6[c] <= cbab1_s5[c];
				hh = {cs_s5[c], 1'b0} - 18'(pbc_pkg::Q_ONE);
				hprod_s6[c] <= 37'(hh[16:0]) * 37'(diff_s5[c]);
			end
			as_s6    <= as_s5;
			ab_s6    <= ab_s5;
			ao_s6    <= ao_s5;
			alpha_s6 <= alpha_s5;
			we_s6    <= we_s5;
			dst_s6   <= dst_s5;
		end

		// stage 7: blend function select
		if (adv[7]) begin
			for (int c = 0; c < 3; c++) begin
				b_s7[c]     <= b_nx[c];
				mcs1_s7[c]  <= mcs1_s6[c];
				cbab1_s7[c] <= cbab1_s6[c];
			end
			as_s7    <= as_s6;
			ab_s7    <= ab_s6;
			ao_s7    <= ao_s6;
			alpha_s7 <= alpha_s6;
			we_s7    <= we_s6;
			dst_s7   <= dst_s6;
		end

		// stage 8: mix source with B by destination alpha
		if (adv[8]) begin
			for (int c = 0; c < 3; c++) begin
				mixsum_s8[c] <= 35'(mcs1_s7[c]) + 35'(ab_s7) * 35'(b_s7[c]);
				cbab1_s8[c]  <= cbab1_s7[c];
			end
			as_s8    <= as_s7;
			ao_s8    <= ao_s7;
			alpha_s8 <= alpha_s7;
			we_s8    <= we_s7;
			dst_s8   <= dst_s7;
		end

		// stage 9
		if (adv[9]) begin
			for (int c = 0; c < 3; c++) begin
				mr = 36'(mixsum_s8[c]) + 36'(pbc_pkg::Q_HALF);
				mas_s9[c]   <= 36'(mr[34:16]) * 36'(as_s8);
				cbab1_s9[c] <= cbab1_s8[c];
			end
			ao_s9    <= ao_s8;
			alpha_s9 <= alpha_s8;
			we_s9    <= we_s8;
			dst_s9   <= dst_s8;
		end

		// stage 10
		if (adv[10]) begin
			for (int c = 0; c < 3; c++) begin
				num_s10[c] <= (52'(mas_s9[c]) << 16) + 52'(cbab1_s9[c]);
			end
			ao_s10    <= ao_s9;
			alpha_s10 <= alpha_s9;
			we_s10    <= we_s9;
			dst_s10   <= dst_s9;
		end

		// stage 11: (255*num + den/2) >> 32, den = ao << 32
		if (adv[11]) begin
			for (int c = 0; c < 3; c++) begin
				nw = (60'(num_s10[c]) << 8) - 60'(num_s10[c]) + (60'(ao_s10) << 31);
				nh_s11[c] <= nw[59:32];
			end
			ao_s11    <= ao_s10;
			alpha_s11 <= alpha_s10;
			we_s11    <= we_s10;
			dst_s11   <= dst_s10;
		end

		// stage 12: saturation check, quotient bits 7 and 6
		if (adv[12]) begin
			for (int c = 0; c < 3; c++) begin
				sat_s12[c] <= (nh_s11[c] >= (28'(ao_s11) << 8));
				rem_s12[c] <= d12b[c][27:0];
				q_s12[c]   <= {d12a[c][28], d12b[c][28], 6'd0};
			end
			ao_s12    <= ao_s11;
			alpha_s12 <= alpha_s11;
			we_s12    <= we_s11;
			dst_s12   <= dst_s11;
		end

		// stage 13: bits 5 and 4
		if (adv[13]) begin
			for (int c = 0; c < 3; c++) begin
				sat_s13[c] <= sat_s12[c];
				rem_s13[c] <= d13b[c][27:0];
				q_s13[c]   <= {q_s12[c][7:6], d13a[c][28], d13b[c][28], 4'd0};
			end
			ao_s13    <= ao_s12;
			alpha_s13 <= alpha_s12;
			we_s13    <= we_s12;
			dst_s13   <= dst_s12;
		end

		// stage 14: bits 3 and 2
		if (adv[14]) begin
			for (int c = 0; c < 3; c++) begin
				sat_s14[c] <= sat_s13[c];
				rem_s14[c] <= d14b[c][27:0];
				q_s14[c]   <= {q_s13[c][7:4], d14a[c][28], d14b[c][28], 2'd0};
			end
			ao_s14    <= ao_s13;
			alpha_s14 <= alpha_s13;
			we_s14    <= we_s13;
			dst_s14   <= dst_s13;
		end

		// stage 15: bits 1 and 0
		if (adv[15]) begin
			for (int c = 0; c < 3; c++) begin
				sat_s15[c] <= sat_s14[c];
				q_s15[c]   <= {q_s14[c][7:2], d15a[c][28], d15b[c][28]};
			end
			alpha_s15 <= alpha_s14;
			we_s15    <= we_s14;
			dst_s15   <= dst_s14;
		end

		// output register
		if (adv[NS+1]) begin
			out_pix_q <= we_s15 ? {alpha_s15, byte_nx[2], byte_nx[1], byte_nx[0]} : dst_s15;
			out_we_q  <= we_s15;
		end
	end

endmodule

@@ test/pixel_blend_compositor_checker.sv @@
// Checker for the pixel blend compositor: predicts each composited pixel and compares.
`timescale 1ns / 1ps

module pixel_blend_compositor_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] pixel;
		logic        we;
	} pixel_out_t;

	pbc_pkg::blend_mode_t mode_q;
	// expected items, ring indexed by running counts
	pixel_out_t exp_mem [1024];
	int         wr_cnt;
	int         rd_cnt;

	assign pending = wr_cnt - rd_cnt;

	function automatic longint unsigned byte_to_q(logic [7:0] c);
		return ((longint'(c) * 65536) + 127) / 255;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			t = r + (longint'(1) << b);
			if (t * t <= v) begin
				r = t;
			end
		end
		return r;
	endfunction

	function automatic longint unsigned blend_val(pbc_pkg::blend_mode_t m, longint unsigned cb,
			longint unsigned cs);
		longint unsigned k, t, p, d, diff;
		case (m)
			pbc_pkg::MODE_MULTIPLY: return (cb * cs + 32768) >> 16;
			pbc_pkg::MODE_SCREEN: return 65536 - (((65536 - cb) * (65536 - cs) + 32768) >> 16);
			pbc_pkg::MODE_SOFT: begin
				if (cs <= 32768) begin
					k = 65536 - 2 * cs;
					t = (k * cb * (65536 - cb) + (longint'(1) << 31)) >> 32;
					return (t > cb) ? 0 : cb - t;
				end
				if (cb <= 16384) begin
					p = 4 * 65536 + ((16 * cb * cb + 32768) >> 16) - 12 * cb;
					d = (p * cb + 32768) >> 16;
				end else begin
					d = isqrt(cb << 16);
				end
				diff = (d > cb) ? d - cb : 0;
				d = cb + (((2 * cs - 65536) * diff + 32768) >> 16);
				return (d > 65536) ? 65536 : d;
			end
			default: return cs;
		endcase
	endfunction

	function automatic logic [7:0] mix_channel(pbc_pkg::blend_mode_t m, logic [7:0] cb8,
			logic [7:0] cs8, longint unsigned as, longint unsigned ab, longint unsigned ao);
		longint unsigned cb, cs, bv, mixed, num, den, v;
		cb = byte_to_q(cb8);
		cs = byte_to_q(cs8);
		bv = blend_val(m, cb, cs);
		mixed = ((65536 - ab) * cs + ab * bv + 32768) >> 16;
		num = mixed * as * 65536 + cb * ab * (65536 - as);
		den = ao << 32;
		v = (num * 255 + den / 2) / den;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic pixel_out_t composite(pbc_pkg::blend_mode_t m, logic [63:0] d);
		pixel_out_t r;
		logic [31:0] dst;
		longint unsigned as, ab, ao, a;
		dst = d[63:32];
		if (d[31:24] == 8'd0) begin
			r.pixel = dst;
			r.we = 1'b0;
			return r;
		end
		as = byte_to_q(d[31:24]);
		ab = byte_to_q(dst[31:24]);
		ao = as + ((ab * (65536 - as) + 32768) >> 16);
		a = (ao * 255 + 32768) >> 16;
		r.pixel[7:0]   = mix_channel(m, dst[7:0], d[7:0], as, ab, ao);
		r.pixel[15:8]  = mix_channel(m, dst[15:8], d[15:8], as, ab, ao);
		r.pixel[23:16] = mix_channel(m, dst[23:16], d[23:16], as, ab, ao);
		r.pixel[31:24] = (a > 255) ? 8'd255 : a[7:0];
		r.we = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_out_t e;
		if (!arst_n) begin
			mode_q <= pbc_pkg::MODE_OVER;
			fail_count <= 0;
			wr_cnt <= 0;
			rd_cnt <= 0;
		end else begin
			if (cfg_we) begin
				mode_q <= pbc_pkg::blend_mode_t'(cfg_wdata);
			end
			if (s_tvalid && s_tready) begin
				exp_mem[10'(wr_cnt)] <= composite(mode_q, s_tdata);
				wr_cnt <= wr_cnt + 1;
			end
			if (m_tvalid && m_tready) begin
				if (wr_cnt == rd_cnt) begin
					$error("unexpected result item %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					e = exp_mem[10'(rd_cnt)];
					rd_cnt <= rd_cnt + 1;
					if (e.pixel !== m_tdata) begin
						$error("result_pixel expected %h actual %h", e.pixel, m_tdata);
						fail_count <= fail_count + 1;
					end else if (e.we !== m_tuser) begin
						$error("write_enable expected %b actual %b", e.we, m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

@@ test/pixel_blend_compositor_top_test.sv @@
// Testbench top for the pixel blend compositor: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module pixel_blend_compositor_top_test;

	localparam int LATENCY = pbc_pkg::NUM_STG + 1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // src_red, src_green, src_blue, src_alpha, dst_pixel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // result_pixel
	logic        m_tuser;        // write_enable
	int          fail_count;
	int          pending;
	int          item_total = 0;

	always #2 clk = ~clk;

	pixel_blend_compositor_top i_dut (.*);

	pixel_blend_compositor_checker i_chk (.*);

	// Receiver: stall pattern changes style per phase; some stretches never stall.
	int stall_style = 0;
	always @(posedge clk) begin
		case (stall_style)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 2) == 0);
			default: m_tready <= ($urandom_range(0, 9) < 5);
		endcase
	end

	// Send one item with valid held until accepted.
	task automatic send_item(logic [63:0] d);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		item_total++;
	endtask

	// Drop valid and idle a random gap.
	task automatic gap(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until drained, then for the pipe depth; then the mode register may change.
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_mode(pbc_pkg::blend_mode_t m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand_item(int flavor);
		logic [31:0] src, dst;
		src = $urandom;
		dst = $urandom;
		case (flavor)
			0: src[31:24] = 8'd0;
			1: src[31:24] = 8'd255;
			2: dst[31:24] = 8'd0;
			3: dst[31:24] = 8'd255;
			4: begin
				src = {8'($urandom_range(0, 255)), 24'(0)}
					| {8'd0, {3{8'($urandom_range(0, 1) * 255)}}};
			end
			default: ;
		endcase
		return {dst, src};
	endfunction

	initial begin
		logic [31:0] extremes[8];
		int burst;
		extremes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_FFFF,
			32'h8080_8080, 32'h4040_4040, 32'hFF40_80C0, 32'h01FE_01FE};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each mode over extreme sources and destinations, including
		// zero source alpha, transparent and opaque destinations.
		for (int m = 0; m < 4; m++) begin
			set_mode(pbc_pkg::blend_mode_t'(m));
			stall_style = m;
			for (int k = 0; k < 6; k++) begin
				send_item({extremes[(k + m) % 8], extremes[(k * 3 + 1) % 8]});
			end
			drain_pipe();
		end

		// Random: phases cycle the mode and stall style; mode 3 and mode 0 as bounds.
		for (int ph = 0; ph < 12; ph++) begin
			set_mode(pbc_pkg::blend_mode_t'((ph * 3 + 1) % 4));
			stall_style = ph % 4;
			for (int n = 0; n < 75; ) begin
				burst = $urandom_range(1, 12);
				for (int j = 0; j < burst && n < 75; j++, n++) begin
					send_item(rand_item($urandom_range(0, 8)));
				end
				if (ph % 3 != 0) begin
					gap($urandom_range(0, 4));
				end
				// Hold off until everything in flight has been checked.
				if (n == 40) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
			drain_pipe();
		end

		$display("Covered %0d items over all four blend modes, with transparent, opaque",
			item_total);
		$display("and zero-alpha cases under bursty input and random output stalls.");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
src/pbc_pkg.sv
src/pixel_blend_compositor_top.sv
test/pixel_blend_compositor_checker.sv
test/pixel_blend_compositor_top_test.sv
